// ===== rtl/core/gso_pkg.sv =====
// ----------------------------------------------------------------------------
// gso_pkg
// Shared types and constants of the four-dimensional Gram-Schmidt block.
// ----------------------------------------------------------------------------
package gso_pkg;

   localparam int VECTOR_COUNT  = 4;
   localparam int OUT_FRAC_BITS = 14;
   localparam int WORK_FRAC     = 30;
   localparam int IN_FRAC       = 16;
   localparam int LANES         = 4;
   localparam int BASIS_ROWS    = 3;
   localparam int SQRT_STEPS    = 32;
   localparam int DIV_STEPS     = 31;
   localparam int STEP_W        = $clog2(SQRT_STEPS);

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_TOO_SHORT  = 2'd1,
      ST_FIRST_ZERO = 2'd2,
      ST_AFTER_ZERO = 2'd3
   } gso_status_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_THR_MUL, OP_THR_SAVE, OP_SQ_MUL, OP_SQ_ACC,
      OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
      OP_DOT_MUL, OP_DOT_ACC, OP_DOT_SAVE, OP_SUB_MUL, OP_SUB_ACC,
      OP_W_SAVE, OP_BASIS_WR, OP_EMIT
   } gso_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_THR_MUL, S_THR_SAVE, S_SQ_MUL, S_SQ_ACC, S_LEN_CHECK,
      S_SQRT_INIT, S_SQRT_STEP, S_DIV_INIT, S_DIV_STEP, S_DIV_END,
      S_DOT_MUL, S_DOT_ACC, S_DOT_SAVE, S_SUB_MUL, S_SUB_ACC, S_W_SAVE,
      S_FINISH, S_EMIT
   } gso_state_type;

   typedef struct packed {
      gso_op_type     op;
      logic [1:0]     lane;
      logic [1:0]     row;
      logic           pass;
      logic [1:0]     slot;
      gso_status_type status;
   } gso_cmd_type;

   typedef struct packed {
      logic nonzero;
      logic below_first;
      logic below_second;
   } gso_stat_type;

endpackage

// ===== rtl/core/gso_req_if.sv =====
// ----------------------------------------------------------------------------
// gso_req_if
// Input channel: one Q16.16 four-vector per item.
// ----------------------------------------------------------------------------
interface gso_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vec_x;
   logic signed [31:0] vec_y;
   logic signed [31:0] vec_z;
   logic signed [31:0] vec_w;

   modport source (output valid, vec_x, vec_y, vec_z, vec_w, input ready);
   modport sink   (input valid, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

// ===== rtl/core/gso_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gso_rsp_if
// Result channel: one orthonormal Q1.14 vector with slot and status per item.
// ----------------------------------------------------------------------------
interface gso_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         slot;
   logic signed [15:0] unit_x;
   logic signed [15:0] unit_y;
   logic signed [15:0] unit_z;
   logic signed [15:0] unit_w;
   logic [1:0]         status;

   modport source (output valid, slot, unit_x, unit_y, unit_z, unit_w, status,
                   input ready);
   modport sink   (input valid, slot, unit_x, unit_y, unit_z, unit_w, status,
                   output ready);
endinterface

// ===== rtl/core/gso_datapath.sv =====
// ----------------------------------------------------------------------------
// gso_datapath
// Squarer, multiplier, square-root and four-lane divider units, working
// registers and the basis store, driven one command per cycle.
// ----------------------------------------------------------------------------
module gso_datapath
   import gso_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [16:0]        csr_wr_data,
   input  logic signed [31:0] vec_x,
   input  logic signed [31:0] vec_y,
   input  logic signed [31:0] vec_z,
   input  logic signed [31:0] vec_w,
   input  gso_cmd_type        cmd,
   output gso_stat_type       stat,
   output logic [1:0]         out_slot,
   output logic signed [15:0] out_x,
   output logic signed [15:0] out_y,
   output logic signed [15:0] out_z,
   output logic signed [15:0] out_w,
   output logic [1:0]         out_status
);

   localparam logic signed [38:0] W_LIM  = 39'sh0_8000_0000;
   localparam logic [30:0]        Q_LIM0 = 31'(64'd1 << WORK_FRAC);
   localparam logic [30:0]        Q_LIM1 = 31'(64'd1 << OUT_FRAC_BITS);

   logic [16:0]        min_length_ff;
   logic signed [32:0] x_ff    [LANES];
   logic signed [31:0] n_ff    [LANES];
   logic signed [38:0] a_ff    [LANES];
   logic signed [15:0] res_ff  [LANES];
   logic signed [15:0] basis_ff [BASIS_ROWS][LANES];
   logic signed [33:0] d_ff    [BASIS_ROWS];
   logic [33:0]        thr0_ff;
   logic [63:0]        sq_ff;
   logic [63:0]        acc_ff;
   logic signed [49:0] mul_ff;
   logic signed [49:0] dacc_ff;
   logic [63:0]        rad_ff;
   logic [31:0]        root_ff;
   logic [33:0]        rem_ff;
   logic [31:0]        drem_ff  [LANES];
   logic [30:0]        dbits_ff [LANES];
   logic [30:0]        q_ff     [LANES];
   logic               ovf_ff   [LANES];
   logic               neg_ff   [LANES];
   logic [1:0]         out_slot_ff;
   logic signed [15:0] out_unit_ff [LANES];
   logic [1:0]         out_status_ff;

   logic [31:0]        mag      [LANES];
   logic [62:0]        num      [LANES];
   logic [32:0]        dshift   [LANES];
   logic               dge      [LANES];
   logic [30:0]        qmag     [LANES];
   logic signed [31:0] qsigned  [LANES];
   logic signed [32:0] wclamp   [LANES];
   logic [31:0]        sq_op;
   logic [63:0]        sq_prod;
   logic [64:0]        acc_sum;
   logic signed [15:0] mul_b;
   logic signed [33:0] mul_m;
   logic signed [49:0] mul_prod;
   logic [35:0]        rem_shift;
   logic [35:0]        trial;
   logic signed [49:0] dot_shift;
   logic signed [49:0] sub_shift;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         mag[i]    = x_ff[i][32] ? 32'(-x_ff[i]) : 32'(x_ff[i]);
         num[i]    = cmd.pass ? ({31'd0, mag[i]} << OUT_FRAC_BITS)
                              : ({31'd0, mag[i]} << WORK_FRAC);
         dshift[i] = {drem_ff[i], dbits_ff[i][30]};
         dge[i]    = dshift[i] >= {1'b0, root_ff};
         if (cmd.pass) begin
            qmag[i] = (ovf_ff[i] || q_ff[i] > Q_LIM1) ? Q_LIM1 : q_ff[i];
         end else begin
            qmag[i] = (ovf_ff[i] || q_ff[i] > Q_LIM0) ? Q_LIM0 : q_ff[i];
         end
         qsigned[i] = neg_ff[i] ? -$signed({1'b0, qmag[i]}) : $signed({1'b0, qmag[i]});
         if (a_ff[i] > W_LIM) begin
            wclamp[i] = 33'(W_LIM);
         end else if (a_ff[i] < -W_LIM) begin
            wclamp[i] = 33'(-W_LIM);
         end else begin
            wclamp[i] = 33'(a_ff[i]);
         end
      end
      sq_op     = (cmd.op == OP_THR_MUL) ? {15'd0, min_length_ff} : mag[cmd.lane];
      sq_prod   = 64'(sq_op) * 64'(sq_op);
      acc_sum   = {1'b0, acc_ff} + {1'b0, sq_ff};
      mul_b     = basis_ff[cmd.row][cmd.lane];
      mul_m     = (cmd.op == OP_SUB_MUL) ? d_ff[cmd.row] : 34'(n_ff[cmd.lane]);
      mul_prod  = mul_b * mul_m;
      rem_shift = {rem_ff, rad_ff[63:62]};
      trial     = {2'b00, root_ff, 2'b01};
      dot_shift = dacc_ff >>> OUT_FRAC_BITS;
      sub_shift = mul_ff >>> OUT_FRAC_BITS;
   end

   assign stat.nonzero      = (x_ff[0] != 0) || (x_ff[1] != 0) || (x_ff[2] != 0)
                              || (x_ff[3] != 0);
   assign stat.below_first  = acc_ff < {30'd0, thr0_ff};
   // The second check compares against (min_length << 14) squared in Q.60.
   assign stat.below_second = (acc_ff < ({30'd0, thr0_ff} << (2 * (WORK_FRAC - IN_FRAC))))
                              || (acc_ff == 64'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= 17'd7;
      end else if (csr_wr_en) begin
         min_length_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            x_ff[0] <= 33'(vec_x);
            x_ff[1] <= 33'(vec_y);
            x_ff[2] <= 33'(vec_z);
            x_ff[3] <= 33'(vec_w);
            for (int i = 0; i < LANES; i++) res_ff[i] <= '0;
         end
         OP_THR_MUL, OP_SQ_MUL: sq_ff <= sq_prod;
         OP_THR_SAVE: begin
            thr0_ff <= sq_ff[33:0];
            acc_ff  <= '0;
         end
         OP_SQ_ACC: acc_ff <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
         OP_SQRT_INIT: begin
            rad_ff  <= acc_ff;
            root_ff <= '0;
            rem_ff  <= '0;
         end
         OP_SQRT_STEP: begin
            rad_ff <= {rad_ff[61:0], 2'b00};
            if (rem_shift >= trial) begin
               rem_ff  <= 34'(rem_shift - trial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= rem_shift[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         OP_DIV_INIT: begin
            for (int i = 0; i < LANES; i++) begin
               // A quotient of 2^31 or more is clamped whatever its low bits.
               ovf_ff[i]   <= num[i][62:31] >= root_ff;
               drem_ff[i]  <= num[i][62:31];
               dbits_ff[i] <= num[i][30:0];
               q_ff[i]     <= '0;
               neg_ff[i]   <= x_ff[i][32];
            end
         end
         OP_DIV_STEP: begin
            for (int i = 0; i < LANES; i++) begin
               dbits_ff[i] <= {dbits_ff[i][29:0], 1'b0};
               q_ff[i]     <= {q_ff[i][29:0], dge[i]};
               drem_ff[i]  <= dge[i] ? 32'(dshift[i] - {1'b0, root_ff}) : dshift[i][31:0];
            end
         end
         OP_DIV_END: begin
            dacc_ff <= '0;
            for (int i = 0; i < LANES; i++) begin
               if (cmd.pass) begin
                  res_ff[i] <= qsigned[i][15:0];
               end else begin
                  n_ff[i] <= qsigned[i];
                  a_ff[i] <= 39'(qsigned[i]);
               end
            end
         end
         OP_DOT_MUL, OP_SUB_MUL: mul_ff <= mul_prod;
         OP_DOT_ACC: dacc_ff <= dacc_ff + mul_ff;
         OP_DOT_SAVE: begin
            d_ff[cmd.row] <= dot_shift[33:0];
            dacc_ff       <= '0;
         end
         OP_SUB_ACC: a_ff[cmd.lane] <= a_ff[cmd.lane] - 39'(sub_shift);
         OP_W_SAVE: begin
            acc_ff <= '0;
            for (int i = 0; i < LANES; i++) x_ff[i] <= wclamp[i];
         end
         OP_BASIS_WR: begin
            for (int i = 0; i < LANES; i++) basis_ff[cmd.slot][i] <= res_ff[i];
         end
         OP_EMIT: begin
            out_slot_ff   <= cmd.slot;
            out_status_ff <= cmd.status;
            for (int i = 0; i < LANES; i++) out_unit_ff[i] <= res_ff[i];
         end
         default: begin
         end
      endcase
   end

   assign out_slot   = out_slot_ff;
   assign out_status = out_status_ff;
   assign out_x      = out_unit_ff[0];
   assign out_y      = out_unit_ff[1];
   assign out_z      = out_unit_ff[2];
   assign out_w      = out_unit_ff[3];

endmodule

// ===== rtl/core/gso_controller.sv =====
// ----------------------------------------------------------------------------
// gso_controller
// Sequencer: walks each item through length checks, square roots, divisions
// and projections, and owns the handshakes, slot counter and zero flag.
// ----------------------------------------------------------------------------
module gso_controller
   import gso_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  gso_stat_type stat,
   output gso_cmd_type  cmd
);

   localparam logic [1:0] LAST_SLOT = 2'(VECTOR_COUNT - 1);
   localparam logic [1:0] LAST_LANE = 2'(LANES - 1);

   gso_state_type  state_ff, state_in;
   logic [1:0]     lane_ff, lane_in;
   logic [1:0]     row_ff, row_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic           pass_ff, pass_in;
   logic [1:0]     slot_ff, slot_in;
   logic           zero_seen_ff, zero_seen_in;
   gso_status_type status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lane_ff      <= '0;
         row_ff       <= '0;
         step_ff      <= '0;
         pass_ff      <= 1'b0;
         slot_ff      <= '0;
         zero_seen_ff <= 1'b0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_ff      <= lane_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         slot_ff      <= slot_in;
         zero_seen_ff <= zero_seen_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign emit = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      lane_in      = lane_ff;
      row_in       = row_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      slot_in      = slot_ff;
      zero_seen_in = zero_seen_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.lane     = lane_ff;
      cmd.row      = row_ff;
      cmd.pass     = pass_ff;
      cmd.slot     = slot_ff;
      cmd.status   = status_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op    = OP_LOAD;
               status_in = ST_OK;
               pass_in   = 1'b0;
               lane_in   = '0;
               row_in    = '0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!stat.nonzero) begin
               status_in    = (slot_ff == 2'd0) ? ST_FIRST_ZERO : ST_OK;
               zero_seen_in = 1'b1;
               state_in     = S_FINISH;
            end else if (zero_seen_ff) begin
               status_in = ST_AFTER_ZERO;
               state_in  = S_FINISH;
            end else begin
               state_in = S_THR_MUL;
            end
         end
         S_THR_MUL: begin
            cmd.op   = OP_THR_MUL;
            state_in = S_THR_SAVE;
         end
         S_THR_SAVE: begin
            cmd.op   = OP_THR_SAVE;
            state_in = S_SQ_MUL;
         end
         S_SQ_MUL: begin
            cmd.op   = OP_SQ_MUL;
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            cmd.op = OP_SQ_ACC;
            if (lane_ff == LAST_LANE) begin
               lane_in  = '0;
               state_in = S_LEN_CHECK;
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = S_SQ_MUL;
            end
         end
         S_LEN_CHECK: begin
            if (pass_ff ? stat.below_second : stat.below_first) begin
               status_in = ST_TOO_SHORT;
               state_in  = S_FINISH;
            end else begin
               state_in = S_SQRT_INIT;
            end
         end
         S_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            step_in  = '0;
            state_in = S_SQRT_STEP;
         end
         S_SQRT_STEP: begin
            cmd.op = OP_SQRT_STEP;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_DIV_INIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.op = OP_DIV_STEP;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_DIV_END;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DIV_END: begin
            cmd.op = OP_DIV_END;
            if (pass_ff) begin
               state_in = S_FINISH;
            end else if (slot_ff == 2'd0) begin
               state_in = S_W_SAVE;
            end else begin
               lane_in  = '0;
               row_in   = '0;
               state_in = S_DOT_MUL;
            end
         end
         S_DOT_MUL: begin
            cmd.op   = OP_DOT_MUL;
            state_in = S_DOT_ACC;
         end
         S_DOT_ACC: begin
            cmd.op = OP_DOT_ACC;
            if (lane_ff == LAST_LANE) begin
               lane_in  = '0;
               state_in = S_DOT_SAVE;
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = S_DOT_MUL;
            end
         end
         S_DOT_SAVE: begin
            cmd.op = OP_DOT_SAVE;
            if (row_ff == slot_ff - 2'd1) begin
               row_in   = '0;
               state_in = S_SUB_MUL;
            end else begin
               row_in   = row_ff + 2'd1;
               state_in = S_DOT_MUL;
            end
         end
         S_SUB_MUL: begin
            cmd.op   = OP_SUB_MUL;
            state_in = S_SUB_ACC;
         end
         S_SUB_ACC: begin
            cmd.op   = OP_SUB_ACC;
            state_in = S_SUB_MUL;
            if (row_ff == slot_ff - 2'd1) begin
               row_in = '0;
               if (lane_ff == LAST_LANE) begin
                  lane_in  = '0;
                  state_in = S_W_SAVE;
               end else begin
                  lane_in = lane_ff + 2'd1;
               end
            end else begin
               row_in = row_ff + 2'd1;
            end
         end
         S_W_SAVE: begin
            cmd.op   = OP_W_SAVE;
            pass_in  = 1'b1;
            lane_in  = '0;
            state_in = S_SQ_MUL;
         end
         S_FINISH: begin
            // The last slot of a set is never projected against, so it is not kept.
            if (slot_ff < 2'(BASIS_ROWS)) begin
               cmd.op = OP_BASIS_WR;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (slot_ff == LAST_SLOT) begin
                  slot_in      = '0;
                  zero_seen_in = 1'b0;
               end else begin
                  slot_in = slot_ff + 2'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("accepted item did not move on to the zero check");

   a_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && slot_ff == LAST_SLOT) |=> (!zero_seen_ff && slot_ff == 2'd0))
      else $error("set wrap did not clear slot and zero flag");

   a_slot_stable: assert property (@(posedge clock) disable iff (reset)
      !emit |=> $stable(slot_ff))
      else $error("slot counter moved without an emitted item");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted item not presented on the result channel");

endmodule

// ===== rtl/core/gram_schmidt_orthonormalize_4d_top.sv =====
// ----------------------------------------------------------------------------
// gram_schmidt_orthonormalize_4d_top
// Four-dimensional Gram-Schmidt orthonormaliser, Q16.16 in, Q1.14 out.
// ----------------------------------------------------------------------------
// Vectors fill slots 0 to 3 of a set in turn; each nonzero one is normalised,
// its projections onto the kept unit vectors of earlier slots are removed and
// it is normalised again. One item is worked on at a time. A nonzero item
// that passes both length checks runs the 32-step square root and the
// 31-step four-lane divider twice each, and the single shared multiplier
// does the projections. A zero item, a nonzero item after a zero and one
// that is too short before projection skip the square root and division.
// The block accepts the next item in the cycle after a result is emitted.
// A finished result waits in the output register while the next item is
// accepted. min_length may be written only while the block is idle.
module gram_schmidt_orthonormalize_4d_top
   import gso_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   gso_req_if.sink     req_if,
   gso_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);

   gso_cmd_type  cmd;
   gso_stat_type stat;

   gso_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gso_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .vec_x       (req_if.vec_x),
      .vec_y       (req_if.vec_y),
      .vec_z       (req_if.vec_z),
      .vec_w       (req_if.vec_w),
      .cmd         (cmd),
      .stat        (stat),
      .out_slot    (rsp_if.slot),
      .out_x       (rsp_if.unit_x),
      .out_y       (rsp_if.unit_y),
      .out_z       (rsp_if.unit_z),
      .out_w       (rsp_if.unit_w),
      .out_status  (rsp_if.status)
   );

endmodule
